// ===== sv/wake_time_sorted_queue_core_defines.svh =====
// assertion macros for the wake-time sorted queue
`ifndef WAKE_TIME_SORTED_QUEUE_CORE_DEFINES_SVH
`define WAKE_TIME_SORTED_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define WTSQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wtsq assertion failed");
// consequent checked in the same cycle as the antecedent
`define WTSQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtsq assertion failed");
// consequent checked in the cycle after the antecedent
`define WTSQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtsq assertion failed");
`else
`define WTSQ_ASSERT(label, clk, rst_n, prop)
`define WTSQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WTSQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/wtsq_pkg.sv =====
// shared types and constants for the wake-time sorted queue
package wtsq_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WAKE_W = 31;
    localparam int TAG_W  = 6;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 88;

    typedef logic [WAKE_W-1:0] t_wake;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_INS_FULL  = 2'd2
    } t_status;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic  ins;
        logic  pop;
        t_wake wake;
        t_tag  tag;
    } t_cell_ctl;

endpackage

// ===== sv/wtsq_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts left or right with its neighbors
module wtsq_cell (
    input  logic               i_clk,
    input  wtsq_pkg::t_cell_ctl i_ctl,
    input  logic               i_is_front,
    input  logic               i_occupied,
    input  logic               i_keep_en,
    input  logic               i_left_keep,
    input  wtsq_pkg::t_wake    i_left_wake,
    input  wtsq_pkg::t_tag     i_left_tag,
    input  wtsq_pkg::t_wake    i_right_wake,
    input  wtsq_pkg::t_tag     i_right_tag,
    output logic               o_keep,
    output wtsq_pkg::t_wake    o_wake,
    output wtsq_pkg::t_tag     o_tag
);
    import wtsq_pkg::*;

    t_wake r_wake, n_wake;
    t_tag  r_tag, n_tag;

    // front stays unless the new time is strictly lower; later slots stay
    // while strictly lower than the new time
    assign o_keep = i_occupied &&
                    (i_is_front ? !(i_ctl.wake < r_wake)
                                : (i_keep_en && (r_wake < i_ctl.wake)));

    always_comb begin
        n_wake = r_wake;
        n_tag  = r_tag;
        if (i_ctl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_wake = i_ctl.wake;
                n_tag  = i_ctl.tag;
            end else begin
                n_wake = i_left_wake;
                n_tag  = i_left_tag;
            end
        end else if (i_ctl.pop) begin
            n_wake = i_right_wake;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wake <= n_wake;
        r_tag  <= n_tag;
    end

    assign o_wake = r_wake;
    assign o_tag  = r_tag;

endmodule

// ===== sv/wake_time_sorted_queue_core.sv =====
// top level of the wake-time sorted queue: cell chain, entry count and result register
//
// Input stream (s side): one transaction per insert or pop. tuser carries the
// action (0 insert, 1 pop); tdata carries wake_time and proc_tag, ignored on pop.
// Output stream (m side): exactly one result per input transaction, in order,
// with the popped entry, a status code, the front entry and the occupancy after
// the operation.
// Entries sit in a row of DEPTH cells, front at cell 0. Every cell compares its
// own wake time with the incoming one and either holds, takes the new entry or
// takes its neighbor's entry, so an insert or a pop updates every cell together.
// Latency: the result is valid the cycle after the input is accepted.
// Throughput: one transaction per cycle while the receiver takes results;
// the only limit is the single result register.
// Reset: the entry count clears, the queue is empty and no result is pending;
// cell contents are left as they are and never read while unoccupied.
// Stall: while a result waits, s_tready is low and the queue state is frozen,
// so the head and occupancy shown stay consistent with the pending result.
module wake_time_sorted_queue_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [wtsq_pkg::IN_W-1:0] s_tdata,   // wake_time[30:0], proc_tag[36:31], zero
    input  logic                      s_tuser,   // action
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [wtsq_pkg::OUT_W-1:0] m_tdata   // popped_valid, popped_tag, popped_wake,
                                                 // status, head_valid, head_tag,
                                                 // head_wake, occupancy, zero
);
    import wtsq_pkg::*;

    `include "wake_time_sorted_queue_core_defines.svh"

    t_count  r_count, n_count;
    logic    r_out_valid;
    logic    r_pop_valid;
    t_tag    r_pop_tag;
    t_wake   r_pop_wake;
    t_status r_status, n_status;

    logic      w_accept;
    logic      w_is_pop;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    logic  w_keep [DEPTH];
    t_wake w_wake [DEPTH];
    t_tag  w_tag  [DEPTH];

    assign s_tready = !r_out_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;
    assign w_is_pop = s_tuser;
    assign w_full   = (r_count == t_count'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctl.ins  = w_accept && !w_is_pop && !w_full;
    assign w_ctl.pop  = w_accept && w_is_pop && !w_empty;
    assign w_ctl.wake = s_tdata[WAKE_W-1:0];
    assign w_ctl.tag  = s_tdata[WAKE_W+TAG_W-1:WAKE_W];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic  w_left_keep;
            logic  w_keep_en;
            t_wake w_left_wake, w_right_wake;
            t_tag  w_left_tag, w_right_tag;

            if (gi == 0) begin : g_front
                assign w_left_keep = 1'b1;
                assign w_keep_en   = 1'b1;
                assign w_left_wake = w_ctl.wake;
                assign w_left_tag  = w_ctl.tag;
            end else begin : g_mid
                assign w_left_keep = w_keep[gi-1];
                assign w_keep_en   = w_keep[0];
                assign w_left_wake = w_wake[gi-1];
                assign w_left_tag  = w_tag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_right_wake = w_ctl.wake;
                assign w_right_tag  = w_ctl.tag;
            end else begin : g_inner
                assign w_right_wake = w_wake[gi+1];
                assign w_right_tag  = w_tag[gi+1];
            end

            wtsq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_is_front   (gi == 0),
                .i_occupied   (r_count > t_count'(gi)),
                .i_keep_en    (w_keep_en),
                .i_left_keep  (w_left_keep),
                .i_left_wake  (w_left_wake),
                .i_left_tag   (w_left_tag),
                .i_right_wake (w_right_wake),
                .i_right_tag  (w_right_tag),
                .o_keep       (w_keep[gi]),
                .o_wake       (w_wake[gi]),
                .o_tag        (w_tag[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (w_is_pop) begin
            if (w_empty) begin
                n_status = ST_POP_EMPTY;
            end else begin
                n_count = r_count - t_count'(1);
            end
        end else begin
            if (w_full) begin
                n_status = ST_INS_FULL;
            end else begin
                n_count = r_count + t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_pop_valid <= w_ctl.pop;
            r_pop_tag   <= w_ctl.pop ? w_tag[0] : '0;
            r_pop_wake  <= w_ctl.pop ? w_wake[0] : '0;
        end
    end

    // head fields read straight from the front cell, which is frozen while a result waits
    logic  w_head_valid;
    t_tag  w_head_tag;
    t_wake w_head_wake;

    assign w_head_valid = !w_empty;
    assign w_head_tag   = w_head_valid ? w_tag[0] : '0;
    assign w_head_wake  = w_head_valid ? w_wake[0] : '0;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_count, w_head_wake, w_head_tag, w_head_valid,
                       r_status, r_pop_wake, r_pop_tag, r_pop_valid};

    `WTSQ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= t_count'(DEPTH))
    `WTSQ_ASSERT_NXT(a_pop_empty, i_clk, i_rst_n, w_accept && w_is_pop && w_empty,
                     r_status == ST_POP_EMPTY && r_count == '0 && !r_pop_valid)
    `WTSQ_ASSERT_NXT(a_ins_count, i_clk, i_rst_n, w_ctl.ins,
                     r_count == $past(r_count) + t_count'(1))
    `WTSQ_ASSERT_NXT(a_stall_frozen, i_clk, i_rst_n, r_out_valid && !m_tready,
                     $stable(r_count) && r_out_valid)

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the wake-time sorted queue core
`timescale 1ns / 100ps

module testbench;
    import wtsq_pkg::*;

    // result word as packed on m_tdata, lowest field last
    typedef struct packed {
        logic [2:0] pad;
        t_count     occupancy;
        t_wake      head_wake;
        t_tag       head_tag;
        logic       head_valid;
        t_status    status;
        t_wake      popped_wake;
        t_tag       popped_tag;
        logic       popped_valid;
    } t_result;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;
    localparam t_wake WAKE_MAX  = 31'h7FFF_FFFF;

    class t_wake_queue_scoreboard;
        t_wake       wake_slot [DEPTH];
        t_tag        tag_slot [DEPTH];
        int unsigned held = 0;
        t_result     pending [$];
        int unsigned failures = 0;

        // apply one accepted request to the sorted store and queue its result
        function void note_request(logic act, t_wake wake, t_tag tag);
            t_result     r;
            int unsigned pos;
            r = '0;
            r.status = ST_OK;
            if (act == ACT_INSERT) begin
                if (held >= DEPTH) begin
                    r.status = ST_INS_FULL;
                end else begin
                    // ties with the front land behind it
                    if (held == 0 || wake < wake_slot[0]) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < held && wake_slot[pos] < wake) pos++;
                    end
                    for (int i = held; i > pos; i--) begin
                        wake_slot[i] = wake_slot[i-1];
                        tag_slot[i]  = tag_slot[i-1];
                    end
                    wake_slot[pos] = wake;
                    tag_slot[pos]  = tag;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    r.popped_valid = 1'b1;
                    r.popped_tag   = tag_slot[0];
                    r.popped_wake  = wake_slot[0];
                    for (int i = 1; i < held; i++) begin
                        wake_slot[i-1] = wake_slot[i];
                        tag_slot[i-1]  = tag_slot[i];
                    end
                    held--;
                end
            end
            if (held > 0) begin
                r.head_valid = 1'b1;
                r.head_tag   = tag_slot[0];
                r.head_wake  = wake_slot[0];
            end
            r.occupancy = t_count'(held);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned exp_v,
                                    longint unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                failures++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $error("result transaction with no request outstanding");
                failures++;
                return;
            end
            exp_r = pending.pop_front();
            compare_field("popped_valid", exp_r.popped_valid, got.popped_valid);
            compare_field("popped_tag", exp_r.popped_tag, got.popped_tag);
            compare_field("popped_wake", exp_r.popped_wake, got.popped_wake);
            compare_field("status", exp_r.status, got.status);
            compare_field("head_valid", exp_r.head_valid, got.head_valid);
            compare_field("head_tag", exp_r.head_tag, got.head_tag);
            compare_field("head_wake", exp_r.head_wake, got.head_wake);
            compare_field("occupancy", exp_r.occupancy, got.occupancy);
        endfunction
    endclass

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;   // wake_time, proc_tag, zero
    logic               s_tuser  = 1'b0; // action
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;         // see t_result

    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 80;

    t_wake_queue_scoreboard board;

    wake_time_sorted_queue_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure and checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_result(t_result'(m_tdata));
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(input logic act, input t_wake wake, input t_tag tag);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, tag, wake};
        do @(posedge i_clk); while (!s_tready);
        board.note_request(act, wake, tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_wake pick_wake();
        case ($urandom_range(3))
            0:       return t_wake'($urandom_range(0, 7));       // many ties
            1:       return t_wake'($urandom_range(1000, 1031));
            2:       return t_wake'($urandom);
            default: return WAKE_MAX - t_wake'($urandom_range(0, 3));
        endcase
    endfunction

    // runs of fill-biased, mixed and drain-biased traffic so the queue
    // swings between empty and full
    task automatic run_traffic(input int unsigned count);
        int unsigned done;
        int unsigned run_len;
        int unsigned ins_pct;
        int unsigned mode;
        done = 0;
        mode = 0;
        while (done < count) begin
            case (mode % 3)
                0: begin
                    ins_pct = 90;
                    run_len = $urandom_range(70, 130);
                end
                1: begin
                    ins_pct = 50;
                    run_len = $urandom_range(20, 60);
                end
                default: begin
                    ins_pct = 12;
                    run_len = $urandom_range(70, 130);
                end
            endcase
            for (int k = 0; k < run_len && done < count; k++) begin
                if ($urandom_range(99) < ins_pct)
                    send_request(ACT_INSERT, pick_wake(), t_tag'($urandom));
                else
                    send_request(ACT_POP, t_wake'($urandom), t_tag'($urandom));
                done++;
            end
            mode++;
        end
    endtask

    initial begin
        board = new;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop on empty, with the ignored fields all ones
        send_request(ACT_POP, WAKE_MAX, 6'h3F);
        send_request(ACT_INSERT, 31'd100, 6'd1);
        // tie with the front goes right behind it
        send_request(ACT_INSERT, 31'd100, 6'd2);
        send_request(ACT_INSERT, 31'd50, 6'd3);
        // tie with later entries goes ahead of them
        send_request(ACT_INSERT, 31'd100, 6'd4);
        send_request(ACT_INSERT, 31'd0, 6'd0);
        send_request(ACT_INSERT, WAKE_MAX, 6'd63);
        send_request(ACT_INSERT, WAKE_MAX, 6'd62);
        send_request(ACT_INSERT, 31'h2AAA_AAAA, 6'h15);
        send_request(ACT_INSERT, 31'h5555_5555, 6'h2A);
        for (int k = 0; k < 10; k++) send_request(ACT_POP, t_wake'($urandom), t_tag'($urandom));
        send_request(ACT_POP, 31'd0, 6'd0);

        run_traffic(650);
        wait_for_drain();
        send_idle_pct = 80;
        recv_idle_pct = 18;
        run_traffic(650);
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(650);

        wait_for_drain();
        repeat (5) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wtsq_pkg.sv
sv/wtsq_cell.sv
sv/wake_time_sorted_queue_core.sv
tb/testbench.sv
